@@ hw/rtl/memory_lcd_frame_store_refresh_core_defines.svh @@
// Assertion macros shared by the frame store refresh core.
`ifndef MEMORY_LCD_FRAME_STORE_REFRESH_CORE_DEFINES_SVH
`define MEMORY_LCD_FRAME_STORE_REFRESH_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define MLCD_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("frame store core check failed");
`define MLCD_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("frame store core check failed");
`else
`define MLCD_ASSERT(lbl, clk, rst, prop)
`define MLCD_ASSERT_NR(lbl, clk, prop)
`endif
`endif

@@ hw/rtl/mlcd_pkg.sv @@
// Shared constants, types and helpers of the memory LCD frame store core.
package mlcd_pkg;

  localparam int PANEL_WIDTH_DEF  = 128;
  localparam int PANEL_HEIGHT_DEF = 128;

  // Command opcodes of an input word.
  localparam logic [1:0] OP_FILL = 2'd0;
  localparam logic [1:0] OP_DRAW = 2'd1;
  localparam logic [1:0] OP_SEND = 2'd2;

  // Decoded kind of an input word after range checks.
  localparam logic [1:0] K_NONE = 2'd0;
  localparam logic [1:0] K_FILL = 2'd1;
  localparam logic [1:0] K_DRAW = 2'd2;
  localparam logic [1:0] K_SEND = 2'd3;

  // Source of the next output byte.
  localparam logic [1:0] SEL_CMD  = 2'd0;
  localparam logic [1:0] SEL_NUM  = 2'd1;
  localparam logic [1:0] SEL_DATA = 2'd2;
  localparam logic [1:0] SEL_STOP = 2'd3;

  localparam logic [7:0] LCD_CMD_WRITE = 8'h80;
  localparam logic [7:0] LCD_CMD_VCOM  = 8'h40;
  localparam logic [7:0] LCD_STOP      = 8'h00;
  localparam int         VCOM_BIT      = 3;

  typedef struct packed {
    logic       load;
    logic       clear;
    logic       fill_wr;
    logic       draw_wr;
    logic       mem_rd;
    logic       addr_inc;
    logic       out_load;
    logic [1:0] out_sel;
  } mlcd_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       addr_last;
    logic       pf_valid;
    logic       rd_done;
    logic       out_free;
  } mlcd_stat_t;

  function automatic logic [7:0] reverse8(input logic [7:0] v);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) begin
      r[k] = v[7 - k];
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/mlcd_datapath.sv @@
// Datapath: frame store memory, address and column counters, VCOM count, output register.
module mlcd_datapath #(
  parameter int PANEL_WIDTH  = mlcd_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = mlcd_pkg::PANEL_HEIGHT_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [1:0]           opcode,
  input  logic [7:0]           fill_pattern,
  input  logic [6:0]           pixel_x,
  input  logic [6:0]           pixel_y,
  input  logic                 pixel_on,
  input  logic                 draw_color,
  input  logic [5:0]           store_row,
  input  logic [6:0]           line_offset,
  input  mlcd_pkg::mlcd_cmd_t  cmd,
  output mlcd_pkg::mlcd_stat_t stat,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic [7:0]           spi_byte,
  output logic                 last_byte
);

  localparam int ROW_BYTES   = PANEL_WIDTH / 8;
  localparam int STORE_ROWS  = PANEL_HEIGHT / 2;
  localparam int STORE_BYTES = ROW_BYTES * STORE_ROWS;
  localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int CW = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;

  logic [7:0]    mem [STORE_BYTES];
  logic [7:0]    rd_data;
  logic [AW-1:0] addr;
  logic [CW-1:0] col;
  logic          rd_done;
  logic          pf_valid;
  logic [4:0]    vcom_count;
  logic [7:0]    pattern;
  logic [7:0]    mask;
  logic          pix_value;
  logic [7:0]    line_rev;

  logic [7:0]    line_sum;
  logic          draw_ok;
  logic          send_ok;
  logic [1:0]    kind;
  logic [AW-1:0] draw_addr;
  logic [AW-1:0] send_addr;
  logic          mem_we;
  logic [7:0]    wr_data;
  logic          load_data;
  logic [7:0]    out_byte;

  // Decode and range checks of the word offered at the input.
  assign line_sum  = {2'b00, store_row} + {1'b0, line_offset};
  assign draw_ok   = (10'(pixel_x) < 10'(PANEL_WIDTH)) && (pixel_y < 7'(STORE_ROWS));
  assign send_ok   = ({1'b0, store_row} < 7'(STORE_ROWS)) && (line_sum < 8'(PANEL_HEIGHT));
  assign draw_addr = AW'(32'(pixel_y) * ROW_BYTES + 32'(pixel_x[6:3]));
  assign send_addr = AW'(32'(store_row) * ROW_BYTES);

  always_comb begin
    unique case (opcode)
      mlcd_pkg::OP_FILL: kind = mlcd_pkg::K_FILL;
      mlcd_pkg::OP_DRAW: kind = draw_ok ? mlcd_pkg::K_DRAW : mlcd_pkg::K_NONE;
      mlcd_pkg::OP_SEND: kind = send_ok ? mlcd_pkg::K_SEND : mlcd_pkg::K_NONE;
      default:           kind = mlcd_pkg::K_NONE;
    endcase
  end

  // Item payload, captured when the word is taken.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pattern   <= fill_pattern;
      mask      <= 8'h80 >> pixel_x[2:0];
      pix_value <= draw_color ? pixel_on : ~pixel_on;
      line_rev  <= mlcd_pkg::reverse8(line_sum + 8'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      addr       <= '0;
      col        <= '0;
      rd_done    <= 1'b0;
      pf_valid   <= 1'b0;
      vcom_count <= '0;
    end else begin
      if (cmd.load) begin
        col     <= '0;
        rd_done <= 1'b0;
        unique case (kind)
          mlcd_pkg::K_DRAW: addr <= draw_addr;
          mlcd_pkg::K_SEND: addr <= send_addr;
          default:          addr <= '0;
        endcase
      end else if (cmd.addr_inc) begin
        addr <= addr + AW'(1);
        if (cmd.mem_rd) begin
          col <= col + CW'(1);
          if (col == CW'(ROW_BYTES - 1)) begin
            rd_done <= 1'b1;
          end
        end
      end
      // A draw uses up its read byte in the write cycle.
      if (cmd.mem_rd) begin
        pf_valid <= 1'b1;
      end else if (load_data || cmd.draw_wr) begin
        pf_valid <= 1'b0;
      end
      if (cmd.out_load && cmd.out_sel == mlcd_pkg::SEL_CMD) begin
        vcom_count <= vcom_count + 5'd1;
      end
    end
  end

  // Single-port frame store with registered read.
  assign mem_we = cmd.fill_wr || cmd.draw_wr;

  always_comb begin
    if (cmd.draw_wr) begin
      wr_data = pix_value ? (rd_data | mask) : (rd_data & ~mask);
    end else if (cmd.clear) begin
      wr_data = 8'h00;
    end else begin
      wr_data = pattern;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_rd) begin
      rd_data <= mem[addr];
    end
  end

  // Output register.
  assign load_data = cmd.out_load && (cmd.out_sel == mlcd_pkg::SEL_DATA);

  always_comb begin
    case (cmd.out_sel)
      mlcd_pkg::SEL_CMD:
        out_byte = mlcd_pkg::LCD_CMD_WRITE |
                   (vcom_count[mlcd_pkg::VCOM_BIT] ? mlcd_pkg::LCD_CMD_VCOM : 8'h00);
      mlcd_pkg::SEL_NUM:  out_byte = line_rev;
      mlcd_pkg::SEL_DATA: out_byte = ~rd_data;
      default:            out_byte = mlcd_pkg::LCD_STOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      spi_byte  <= out_byte;
      last_byte <= (cmd.out_sel == mlcd_pkg::SEL_STOP);
    end
  end

  assign stat.kind      = kind;
  assign stat.addr_last = (addr == AW'(STORE_BYTES - 1));
  assign stat.pf_valid  = pf_valid;
  assign stat.rd_done   = rd_done;
  assign stat.out_free  = !out_valid || !out_stall;

endmodule

@@ hw/rtl/mlcd_ctrl.sv @@
// Controller state machine sequencing clear, fill, draw and line sends.
module mlcd_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mlcd_pkg::mlcd_stat_t stat,
  output mlcd_pkg::mlcd_cmd_t  cmd
);

  localparam logic [2:0] S_CLEAR    = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_FILL     = 3'd2;
  localparam logic [2:0] S_DRAW_RD  = 3'd3;
  localparam logic [2:0] S_DRAW_WR  = 3'd4;
  localparam logic [2:0] S_SEND_CMD = 3'd5;
  localparam logic [2:0] S_SEND_NUM = 3'd6;
  localparam logic [2:0] S_SEND_DAT = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       stop_pend;
  logic       stop_pend_next;
  logic       load_data;
  logic       rd_issue;

  assign in_stall  = (state != S_IDLE) || stop_pend;
  // The prefetched byte is only moved out while the data bytes are sent.
  assign load_data = (state == S_SEND_DAT) && stat.pf_valid && stat.out_free;
  assign rd_issue  = !stat.rd_done && (!stat.pf_valid || load_data);

  always_comb begin
    state_next     = state;
    stop_pend_next = stop_pend;
    cmd            = '0;
    unique case (state) inside
      S_CLEAR, S_FILL: begin
        cmd.fill_wr  = 1'b1;
        cmd.clear    = (state == S_CLEAR);
        cmd.addr_inc = 1'b1;
        if (stat.addr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (stop_pend) begin
          // The stop word of the last line waits for room in the output register.
          if (stat.out_free) begin
            cmd.out_load   = 1'b1;
            cmd.out_sel    = mlcd_pkg::SEL_STOP;
            stop_pend_next = 1'b0;
          end
        end else if (in_valid) begin
          cmd.load = 1'b1;
          unique case (stat.kind)
            mlcd_pkg::K_FILL: state_next = S_FILL;
            mlcd_pkg::K_DRAW: state_next = S_DRAW_RD;
            mlcd_pkg::K_SEND: state_next = S_SEND_CMD;
            default:          state_next = S_IDLE;
          endcase
        end
      end
      S_DRAW_RD: begin
        cmd.mem_rd = 1'b1;
        state_next = S_DRAW_WR;
      end
      S_DRAW_WR: begin
        cmd.draw_wr = 1'b1;
        state_next  = S_IDLE;
      end
      S_SEND_CMD: begin
        cmd.mem_rd   = rd_issue;
        cmd.addr_inc = rd_issue;
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = mlcd_pkg::SEL_CMD;
          state_next   = S_SEND_NUM;
        end
      end
      S_SEND_NUM: begin
        cmd.mem_rd   = rd_issue;
        cmd.addr_inc = rd_issue;
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = mlcd_pkg::SEL_NUM;
          state_next   = S_SEND_DAT;
        end
      end
      S_SEND_DAT: begin
        cmd.mem_rd   = rd_issue;
        cmd.addr_inc = rd_issue;
        cmd.out_load = load_data;
        cmd.out_sel  = mlcd_pkg::SEL_DATA;
        if (load_data && stat.rd_done) begin
          state_next     = S_IDLE;
          stop_pend_next = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      stop_pend <= 1'b0;
    end else begin
      state     <= state_next;
      stop_pend <= stop_pend_next;
    end
  end

endmodule

@@ hw/rtl/memory_lcd_frame_store_refresh_core.sv @@
// Top level of the memory LCD frame store and line refresh core.
//
// Input channel: in_valid/in_stall carry one command word (fill, draw pixel or
// send line) per handshake; a word is taken on a rising edge with in_valid high
// and in_stall low. Output channel: out_valid/out_stall carry one SPI word per
// handshake, spi_byte with last_byte set on the stop word of a line.
// A fill writes all PANEL_WIDTH/8 * PANEL_HEIGHT/2 store bytes (1024 at the default
// size), one byte per cycle, and holds the input off until it is done.
// A draw is a read-modify-write of one store byte.
// A send emits PANEL_WIDTH/8 + 3 words; store bytes are read one per cycle ahead
// of the output register while the output is not stalled.
// Draws and sends outside the store or panel are taken and dropped.
// After reset the store is cleared by a pass of one byte per cycle, the same
// length as a fill, while in_stall stays high; the VCOM count resets to zero.
// When the receiver stalls, the output word holds and the core waits with the
// next store byte prefetched; the input is stalled until the line is done.
module memory_lcd_frame_store_refresh_core #(
  parameter int PANEL_WIDTH  = mlcd_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = mlcd_pkg::PANEL_HEIGHT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] opcode,
  input  logic [7:0] fill_pattern,
  input  logic [6:0] pixel_x,
  input  logic [6:0] pixel_y,
  input  logic       pixel_on,
  input  logic       draw_color,
  input  logic [5:0] store_row,
  input  logic [6:0] line_offset,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] spi_byte,
  output logic       last_byte
);

`include "memory_lcd_frame_store_refresh_core_defines.svh"

  mlcd_pkg::mlcd_cmd_t  cmd;
  mlcd_pkg::mlcd_stat_t stat;

  // The controller only sequences; every stored byte and counter lives in the datapath.
  mlcd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  mlcd_datapath #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .opcode       (opcode),
    .fill_pattern (fill_pattern),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .pixel_on     (pixel_on),
    .draw_color   (draw_color),
    .store_row    (store_row),
    .line_offset  (line_offset),
    .cmd          (cmd),
    .stat         (stat),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .spi_byte     (spi_byte),
    .last_byte    (last_byte)
  );

  // The clearing pass always follows reset, so the input is held off.
  `MLCD_ASSERT_NR(a_clear_after_reset, clk, rst |=> in_stall)
  // A prefetched store byte means a line or a draw is still in flight.
  `MLCD_ASSERT(a_pf_blocks_input, clk, rst, stat.pf_valid |-> in_stall)
  // The store has one port: no read in a cycle that writes.
  `MLCD_ASSERT(a_single_port, clk, rst, cmd.mem_rd |-> !(cmd.fill_wr || cmd.draw_wr))

endmodule

@@ bench/memory_lcd_frame_store_refresh_core_tb.sv @@
// Self-checking testbench for the memory LCD frame store and line refresh core.
module memory_lcd_frame_store_refresh_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Geometry of the store as the core is built here.
  localparam int PANEL_W    = mlcd_pkg::PANEL_WIDTH_DEF;
  localparam int PANEL_H    = mlcd_pkg::PANEL_HEIGHT_DEF;
  localparam int ROW_BYTES  = PANEL_W / 8;
  localparam int STORE_ROWS = PANEL_H / 2;
  localparam int STORE_SIZE = ROW_BYTES * STORE_ROWS;

  // Command codes and the stop byte, as the core defines them.
  localparam logic [1:0] OP_FILL  = mlcd_pkg::OP_FILL;
  localparam logic [1:0] OP_DRAW  = mlcd_pkg::OP_DRAW;
  localparam logic [1:0] OP_SEND  = mlcd_pkg::OP_SEND;
  localparam logic [7:0] LCD_STOP = mlcd_pkg::LCD_STOP;

  // The fourth opcode has no meaning; the core must take it and stay silent.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Command byte of a line with VCOM low and with VCOM high.
  localparam logic [7:0] CMD_LO = mlcd_pkg::LCD_CMD_WRITE;
  localparam logic [7:0] CMD_HI = mlcd_pkg::LCD_CMD_WRITE | mlcd_pkg::LCD_CMD_VCOM;

  localparam int RANDOM_ITEMS = 290;
  localparam int QUIET_ITEMS  = 40;   // tail of the run with no idling at all
  localparam int HOLD_AT      = 60;   // random item at which the long hold starts
  localparam int LONG_HOLD    = 400;  // cycles the receiver holds off in one go
  localparam int TAIL_CYCLES  = 40;   // settle time after the last expected word

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] pattern;
    logic [6:0] x;
    logic [6:0] y;
    logic       on;
    logic       color;
    logic [5:0] row;
    logic [6:0] offset;
  } lcd_cmd_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } spi_word_t;

  // How a row of the directed plan is checked: by the line predictor, against
  // a line typed into the plan (uniform data bytes), or as giving no words.
  typedef enum logic [1:0] {ROW_PRED, ROW_LINE, ROW_NONE} row_kind_t;

  typedef struct packed {
    lcd_cmd_t   c;
    row_kind_t  kind;
    logic [7:0] cmd_b;
    logic [7:0] num_b;
    logic [7:0] data_b;
  } plan_row_t;

  localparam int PLAN_ROWS = 24;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] opcode;
  logic [7:0] fill_pattern;
  logic [6:0] pixel_x;
  logic [6:0] pixel_y;
  logic       pixel_on;
  logic       draw_color;
  logic [5:0] store_row;
  logic [6:0] line_offset;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] spi_byte;
  logic       last_byte;

  // Shadow of the core's pixel memory and VCOM line counter.
  logic [7:0] shadow_store [STORE_SIZE];
  logic [4:0] shadow_vcom;

  // SPI words still owed by the core, oldest first.
  spi_word_t  spi_expected [$];

  int         err_count;
  bit         quiet;         // set for the last stretch: no idling on either side
  bit         hold_pending;  // asks the receiver for one long hold-off
  int         send_mode;     // 0 no gaps, 1 sparse gaps, 2 dense gaps

  memory_lcd_frame_store_refresh_core #(
    .PANEL_WIDTH (PANEL_W),
    .PANEL_HEIGHT(PANEL_H)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .fill_pattern(fill_pattern),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_on    (pixel_on),
    .draw_color  (draw_color),
    .store_row   (store_row),
    .line_offset (line_offset),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .spi_byte    (spi_byte),
    .last_byte   (last_byte)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Applies one command to the shadow store. A line that is really sent bumps
  // the VCOM counter; its words are queued only when queue_words is set, so
  // rows with a typed expectation still keep the shadow state in step.
  function automatic void apply_command(input lcd_cmd_t c, input bit queue_words);
    int         line_no;
    int         idx;
    logic [7:0] mask;
    logic       pix;
    logic [7:0] num;
    logic [7:0] num_rev;
    logic [7:0] cmd_b;
    case (c.op)
      OP_FILL: begin
        foreach (shadow_store[i]) shadow_store[i] = c.pattern;
      end
      OP_DRAW: begin
        // Draws off the panel or below the stored half are dropped.
        if (int'(c.x) < PANEL_W && int'(c.y) < STORE_ROWS) begin
          idx  = int'(c.y) * ROW_BYTES + int'(c.x >> 3);
          mask = 8'h80 >> c.x[2:0];
          pix  = c.color ? c.on : ~c.on;
          shadow_store[idx] = pix ? (shadow_store[idx] | mask)
                                  : (shadow_store[idx] & ~mask);
        end
      end
      OP_SEND: begin
        line_no = int'(c.row) + int'(c.offset);
        // Rows outside the store or lines past the panel send nothing and
        // leave VCOM alone.
        if (int'(c.row) < STORE_ROWS && line_no < PANEL_H) begin
          cmd_b = shadow_vcom[mlcd_pkg::VCOM_BIT] ? CMD_HI : CMD_LO;
          shadow_vcom = shadow_vcom + 5'd1;
          num = 8'(line_no + 1);
          num_rev = {<<{num}};
          if (queue_words) begin
            spi_expected.push_back('{cmd_b, 1'b0});
            spi_expected.push_back('{num_rev, 1'b0});
            for (int k = 0; k < ROW_BYTES; k++)
              spi_expected.push_back('{~shadow_store[int'(c.row) * ROW_BYTES + k], 1'b0});
            spi_expected.push_back('{LCD_STOP, 1'b1});
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Offers one command word. Called right after a falling edge; returns at the
  // rising edge where the word is taken. A random gap may come first, in which
  // case valid drops for the gap and rises again at a later falling edge.
  task automatic offer_command(input lcd_cmd_t c);
    int gap;
    if (!quiet && send_mode != 0 &&
        $urandom_range(0, (send_mode == 1) ? 5 : 1) == 0) begin
      in_valid = 1'b0;
      gap = $urandom_range(1, 13);
      repeat (gap) @(negedge clk);
    end
    opcode       = c.op;
    fill_pattern = c.pattern;
    pixel_x      = c.x;
    pixel_y      = c.y;
    pixel_on     = c.on;
    draw_color   = c.color;
    store_row    = c.row;
    line_offset  = c.offset;
    in_valid     = 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  // Output side: random stall bursts whose density changes from phase to phase,
  // including stretches with none, plus one long hold-off on request so the core
  // backs up and stalls its input.
  initial begin : spi_receiver
    int span;
    int phase_left;
    int mode;
    out_stall  = 1'b0;
    mode       = 0;
    phase_left = 0;
    forever begin
      @(negedge clk);
      if (phase_left <= 0) begin
        mode       = $urandom_range(0, 2);
        phase_left = 200;
      end
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_stall    = 1'b1;
        repeat (LONG_HOLD - 1) @(negedge clk);
        phase_left -= LONG_HOLD;
      end else if (!quiet && mode != 0 &&
                   $urandom_range(0, (mode == 1) ? 9 : 2) == 0) begin
        span      = $urandom_range(1, 13);
        out_stall = 1'b1;
        repeat (span - 1) @(negedge clk);
        phase_left -= span;
      end else begin
        out_stall = 1'b0;
        phase_left--;
      end
    end
  end

  // Every word the core hands over is compared with the oldest one owed.
  always @(posedge clk) begin : spi_check
    spi_word_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (spi_expected.size() == 0) begin
        $error("unexpected SPI word: spi_byte %h last_byte %b", spi_byte, last_byte);
        err_count++;
      end else begin
        want = spi_expected.pop_front();
        if (spi_byte !== want.data) begin
          $error("spi_byte: expected %h, got %h", want.data, spi_byte);
          err_count++;
        end
        if (last_byte !== want.last) begin
          $error("last_byte: expected %b, got %b", want.last, last_byte);
          err_count++;
        end
      end
    end
  end

  initial begin : stimulus
    plan_row_t plan [PLAN_ROWS];
    lcd_cmd_t  c;
    int        sel;
    int        pick;

    // Directed plan. The typed lines follow from the VCOM count stepping once
    // per line actually sent: lines 1 to 8 go out with VCOM low, the ninth
    // and tenth with VCOM high. Line number bytes are bit reversed and one
    // based, so line 0 is 80, line 127 is 01, line 5 is 60, line 3 is 20.
    plan = '{
      // Cleared store right after reset: data reads back as all ones.
      '{'{OP_SEND, 8'h00, 7'd0, 7'd0, 1'b0, 1'b0, 6'd0, 7'd0}, ROW_LINE, CMD_LO, 8'h80, 8'hFF},
      // Last store row on the last panel line.
      '{'{OP_SEND, 8'h00, 7'd0, 7'd0, 1'b0, 1'b0, 6'd63, 7'd64}, ROW_LINE, CMD_LO, 8'h01, 8'hFF},
      // One line past the panel: nothing is sent.
      '{'{OP_SEND, 8'h00, 7'd0, 7'd0, 1'b0, 1'b0, 6'd63, 7'd65}, ROW_NONE, 8'h00, 8'h00, 8'h00},
      '{'{OP_SEND, 8'h00, 7'd0, 7'd0, 1'b0, 1'b0, 6'd0, 7'd127}, ROW_LINE, CMD_LO, 8'h01, 8'hFF},
      // Unused opcode with every field at its top value.
      '{'{OP_UNUSED, 8'hFF, 7'd127, 7'd127, 1'b1, 1'b1, 6'd63, 7'd127},
        ROW_NONE, 8'h00, 8'h00, 8'h00},
      '{'{OP_FILL, 8'hFF, 7'd0, 7'd0, 1'b0, 1'b0, 6'd0, 7'd0}, ROW_NONE, 8'h00, 8'h00, 8'h00},
      '{'{OP_SEND, 8'h00, 7'd0, 7'd0, 1'b0, 1'b0, 6'd5, 7'd0}, ROW_LINE, CMD_LO, 8'h60, 8'h00},
      '{'{OP_FILL, 8'h00, 7'd0, 7'd0, 1'b0, 1'b0, 6'd0, 7'd0}, ROW_NONE, 8'h00, 8'h00, 8'h00},
      // Corner pixels, both color senses.
      '{'{OP_DRAW, 8'h00, 7'd0, 7'd0, 1'b1, 1'b1, 6'd0, 7'd0}, ROW_NONE, 8'h00, 8'h00, 8'h00},
      '{'{OP_DRAW, 8'h00, 7'd127, 7'd63, 1'b0, 1'b0, 6'd0, 7'd0}, ROW_NONE, 8'h00, 8'h00, 8'h00},
      '{'{OP_DRAW, 8'h00, 7'd64, 7'd0, 1'b1, 1'b1, 6'd0, 7'd0}, ROW_NONE, 8'h00, 8'h00, 8'h00},
      // Draws below the stored half of the panel are dropped.
      '{'{OP_DRAW, 8'h00, 7'd127, 7'd64, 1'b1, 1'b1, 6'd0, 7'd0}, ROW_NONE, 8'h00, 8'h00, 8'h00},
      '{'{OP_DRAW, 8'h00, 7'd5, 7'd127, 1'b1, 1'b1, 6'd0, 7'd0}, ROW_NONE, 8'h00, 8'h00, 8'h00},
      '{'{OP_SEND, 8'h00, 7'd0, 7'd0, 1'b0, 1'b0, 6'd0, 7'd0}, ROW_PRED, 8'h00, 8'h00, 8'h00},
      '{'{OP_SEND, 8'h00, 7'd0, 7'd0, 1'b0, 1'b0, 6'd63, 7'd0}, ROW_PRED, 8'h00, 8'h00, 8'h00},
      // Clear the corners again through both color senses.
      '{'{OP_DRAW, 8'h00, 7'd0, 7'd0, 1'b1, 1'b0, 6'd0, 7'd0}, ROW_NONE, 8'h00, 8'h00, 8'h00},
      '{'{OP_DRAW, 8'h00, 7'd127, 7'd63, 1'b0, 1'b1, 6'd0, 7'd0}, ROW_NONE, 8'h00, 8'h00, 8'h00},
      '{'{OP_SEND, 8'h00, 7'd0, 7'd0, 1'b0, 1'b0, 6'd0, 7'd0}, ROW_PRED, 8'h00, 8'h00, 8'h00},
      '{'{OP_SEND, 8'h00, 7'd0, 7'd0, 1'b0, 1'b0, 6'd63, 7'd0}, ROW_PRED, 8'h00, 8'h00, 8'h00},
      // Ninth line sent: VCOM goes high.
      '{'{OP_SEND, 8'h00, 7'd0, 7'd0, 1'b0, 1'b0, 6'd1, 7'd2}, ROW_LINE, CMD_HI, 8'h20, 8'hFF},
      '{'{OP_FILL, 8'h5A, 7'd0, 7'd0, 1'b0, 1'b0, 6'd0, 7'd0}, ROW_NONE, 8'h00, 8'h00, 8'h00},
      '{'{OP_SEND, 8'h00, 7'd0, 7'd0, 1'b0, 1'b0, 6'd40, 7'd87}, ROW_LINE, CMD_HI, 8'h01, 8'hA5},
      '{'{OP_DRAW, 8'h00, 7'd3, 7'd2, 1'b0, 1'b1, 6'd0, 7'd0}, ROW_NONE, 8'h00, 8'h00, 8'h00},
      '{'{OP_SEND, 8'h00, 7'd0, 7'd0, 1'b0, 1'b0, 6'd2, 7'd0}, ROW_PRED, 8'h00, 8'h00, 8'h00}
    };

    // Every input is known from time zero, with reset held high at the start.
    rst          = 1'b1;
    in_valid     = 1'b0;
    opcode       = OP_FILL;
    fill_pattern = 8'h00;
    pixel_x      = 7'd0;
    pixel_y      = 7'd0;
    pixel_on     = 1'b0;
    draw_color   = 1'b0;
    store_row    = 6'd0;
    line_offset  = 7'd0;
    err_count    = 0;
    quiet        = 1'b0;
    hold_pending = 1'b0;
    send_mode    = 1;
    foreach (shadow_store[i]) shadow_store[i] = 8'h00;
    shadow_vcom = 5'd0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    // The core clears its store after reset with in_stall high; the first
    // offer simply waits that pass out.

    foreach (plan[i]) begin
      offer_command(plan[i].c);
      apply_command(plan[i].c, plan[i].kind == ROW_PRED);
      if (plan[i].kind == ROW_LINE) begin
        spi_expected.push_back('{plan[i].cmd_b, 1'b0});
        spi_expected.push_back('{plan[i].num_b, 1'b0});
        repeat (ROW_BYTES) spi_expected.push_back('{plan[i].data_b, 1'b0});
        spi_expected.push_back('{LCD_STOP, 1'b1});
      end
      @(negedge clk);
    end

    // Random part. Fills are rare since each one walks the whole store; draws
    // and sends dominate and lean toward the first few rows so that pixels
    // pile up where lines are read back. Most sends land on the panel, the
    // rest use any offset and often fall past the bottom.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 32 == 0) send_mode = $urandom_range(0, 2);
      if (n == HOLD_AT) hold_pending = 1'b1;
      if (n >= RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;

      c.pattern = 8'($urandom_range(0, 255));
      c.x       = 7'($urandom_range(0, 127));
      c.y       = 7'($urandom_range(0, 127));
      c.on      = 1'($urandom_range(0, 1));
      c.color   = 1'($urandom_range(0, 1));
      c.row     = 6'($urandom_range(0, 63));
      c.offset  = 7'($urandom_range(0, 127));

      sel = $urandom_range(0, 99);
      if (sel < 3) begin
        c.op = OP_FILL;
      end else if (sel < 6) begin
        c.op = OP_UNUSED;
      end else if (sel < 53) begin
        c.op = OP_DRAW;
        pick = $urandom_range(0, 19);
        if (pick < 8)       c.y = 7'($urandom_range(0, 7));
        else if (pick < 17) c.y = 7'($urandom_range(0, STORE_ROWS - 1));
      end else begin
        c.op = OP_SEND;
        if ($urandom_range(0, 3) == 0) c.row = 6'($urandom_range(0, 7));
        if ($urandom_range(0, 9) < 7)
          c.offset = 7'($urandom_range(0, PANEL_H - 1 - int'(c.row)));
      end

      offer_command(c);
      apply_command(c, 1'b1);
      @(negedge clk);
    end
    in_valid = 1'b0;

    // Drain: the limit block below catches a core that never finishes.
    while (spi_expected.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // The limit lies well above what a correct run needs, counting the clearing
  // pass, every fill, full stalls on every word and the long hold.
  initial begin : run_limit
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
